// ===== design/cti_pkg.sv =====
// types, codes and constants shared by the calibration table interpolator
`default_nettype none

package cti_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int KEY_W             = 20;
  localparam int COEF_W            = 32;
  localparam int COEF_SET_W        = 3 * COEF_W;
  localparam int FRAC_W            = 16;
  localparam int BLEND_W           = FRAC_W + 1;
  localparam int PROD_W            = COEF_W + 1 + BLEND_W + 1;

  localparam logic [BLEND_W-1:0] BLEND_ONE = BLEND_W'(1) << FRAC_W;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_KEY_ZERO = 3'd2,
    ST_INTERP   = 3'd3,
    ST_NOT_HIT  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH_LO,
    S_FETCH_HI,
    S_GRAB_HI,
    S_DIV,
    S_MUL,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [KEY_W-1:0]         focal;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } in_item_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [COEF_W-1:0] out_a;
    logic signed [COEF_W-1:0] out_b;
    logic signed [COEF_W-1:0] out_c;
    logic [BLEND_W-1:0]       blend;
  } out_item_t;

  // coefficient lane of a packed {a, b, c} set, lane 0 is a
  function automatic logic [COEF_W-1:0] coef_lane(input logic [COEF_SET_W-1:0] set,
                                                  input logic [1:0] lane);
    logic [COEF_W-1:0] w;
    case (lane)
      2'd0:    w = set[3*COEF_W-1:2*COEF_W];
      2'd1:    w = set[2*COEF_W-1:COEF_W];
      default: w = set[COEF_W-1:0];
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/calibration_table_interpolator.sv =====
// calibration table interpolator top level: entry store, key scan, divider and blend
//
// in_valid/in_stall carry one request per item: append an entry, clear the table or
// query an interpolation. out_valid/out_stall return exactly one result per request.
// Requests are taken one at a time; in_stall is high from the edge after a request
// is accepted until its result has moved into the output register.
// An append or clear goes straight to S_EMIT, which loads the output register.
// A query with entries present runs a key scan over the key ram at one read per cycle;
// on a hit it goes on to a coefficient fetch (S_FETCH_LO, S_FETCH_HI, S_GRAB_HI), a
// restoring division skipped for a blend of zero or one, the blend of the three lanes
// on the shared multiplier, and S_EMIT.
// The output register holds a finished result while out_stall is high; the block
// waits with the next result until it is taken, and then accepts the next request.
// Reset empties the table (entry count zero) and clears the output valid flag; the
// ram contents are not touched, since only entries below the count are ever read.
`default_nettype none

module calibration_table_interpolator #(
  parameter int TABLE_ENTRIES = cti_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire cti_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cti_pkg::out_item_t      out_data
);

  import cti_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  state_t state_r, state_nxt;

  logic [CW-1:0]         count_r;
  logic [KEY_W-1:0]      focal_r;
  logic [CW-1:0]         scan_idx_r;
  logic                  rd_vld_r;
  logic [AW-1:0]         cmp_idx_r;
  logic                  has_lo_r, has_hi_r;
  logic [AW-1:0]         lo_idx_r, hi_idx_r;
  logic [KEY_W-1:0]      lo_key_r, hi_key_r;
  logic [COEF_SET_W-1:0] lo_coef_r, hi_coef_r;
  logic [KEY_W:0]        rem_r;
  logic [FRAC_W-1:0]     quo_r;
  logic [KEY_W-1:0]      den_r;
  logic [3:0]            div_cnt_r;
  logic [BLEND_W-1:0]    blend_r;
  logic [1:0]            mul_cnt_r;
  logic signed [PROD_W-1:0] prod_r;
  out_item_t             res_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic                  accept;
  logic                  append_ok;
  logic                  key_we;
  logic [KEY_W-1:0]      key_q;
  logic [COEF_SET_W-1:0] coef_q;
  logic [AW-1:0]         coef_raddr;
  logic                  scan_issue;
  logic                  scan_done;
  logic                  lo_take, hi_take;
  logic [KEY_W-1:0]      den_c, diff_c;
  logic                  div_skip;
  logic [KEY_W:0]        trial;
  logic                  trial_ge;
  logic [COEF_W-1:0]     lo_w, hi_w, prev_lo_w, lerp_w;
  logic signed [COEF_W:0]  diff_w;
  logic                  emit_load;
  out_item_t             res_init;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign append_ok = (in_data.focal != '0) && (count_r < FULL_COUNT);
  assign key_we    = accept && (in_data.opcode == OP_APPEND) && append_ok;

  cti_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_data.focal),
    .raddr (scan_idx_r[AW-1:0]),
    .rdata (key_q)
  );

  assign coef_raddr = (state_r == S_FETCH_HI) ? hi_idx_r : lo_idx_r;

  cti_ram #(
    .WIDTH(COEF_SET_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_coef_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_data.coef_a, in_data.coef_b, in_data.coef_c}),
    .raddr (coef_raddr),
    .rdata (coef_q)
  );

  // key scan
  assign scan_issue = (state_r == S_SCAN) && (scan_idx_r < count_r);
  assign scan_done  = (state_r == S_SCAN) && !scan_issue && !rd_vld_r;
  assign lo_take    = rd_vld_r && (key_q <= focal_r) && (!has_lo_r || key_q > lo_key_r);
  assign hi_take    = rd_vld_r && (key_q >= focal_r) && (!has_hi_r || key_q < hi_key_r);

  // divider setup and step
  assign den_c    = hi_key_r - lo_key_r;
  assign diff_c   = focal_r - lo_key_r;
  assign div_skip = (den_c == '0) || (diff_c >= den_c);
  assign trial    = {rem_r[KEY_W-1:0], 1'b0};
  assign trial_ge = trial >= {1'b0, den_r};

  // blend lanes
  assign lo_w      = coef_lane(lo_coef_r, mul_cnt_r);
  assign hi_w      = coef_lane(hi_coef_r, mul_cnt_r);
  assign diff_w    = $signed({hi_w[COEF_W-1], hi_w}) - $signed({lo_w[COEF_W-1], lo_w});
  assign prev_lo_w = coef_lane(lo_coef_r, mul_cnt_r - 2'd1);
  assign lerp_w    = prev_lo_w + prod_r[FRAC_W+COEF_W-1:FRAC_W];

  assign emit_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    res_init = '0;
    if (in_data.opcode == OP_APPEND) begin
      if (in_data.focal == '0) begin
        res_init.status = ST_KEY_ZERO;
      end else if (count_r >= FULL_COUNT) begin
        res_init.status = ST_FULL;
      end else begin
        res_init.status = ST_STORED;
      end
    end else begin
      res_init.status = ST_NOT_HIT;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.opcode == OP_QUERY && in_data.focal != '0 && count_r != '0) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = (has_lo_r || has_hi_r) ? S_FETCH_LO : S_EMIT;
        end
      end
      S_FETCH_LO: state_nxt = S_FETCH_HI;
      S_FETCH_HI: state_nxt = S_GRAB_HI;
      S_GRAB_HI:  state_nxt = div_skip ? S_MUL : S_DIV;
      S_DIV: begin
        if (div_cnt_r == 4'd15) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_cnt_r == 2'd3) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= scan_issue;
      if (accept && in_data.opcode == OP_APPEND && append_ok) begin
        count_r <= count_r + CW'(1);
      end else if (accept && in_data.opcode == OP_CLEAR) begin
        count_r <= '0;
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      focal_r    <= in_data.focal;
      scan_idx_r <= '0;
      has_lo_r   <= 1'b0;
      has_hi_r   <= 1'b0;
      res_r      <= res_init;
    end

    if (scan_issue) begin
      scan_idx_r <= scan_idx_r + CW'(1);
      cmp_idx_r  <= scan_idx_r[AW-1:0];
    end
    if (lo_take) begin
      has_lo_r <= 1'b1;
      lo_idx_r <= cmp_idx_r;
      lo_key_r <= key_q;
    end
    if (hi_take) begin
      has_hi_r <= 1'b1;
      hi_idx_r <= cmp_idx_r;
      hi_key_r <= key_q;
    end
    // one-sided hit uses the same entry for both ends
    if (scan_done) begin
      if (!has_lo_r) begin
        lo_idx_r <= hi_idx_r;
        lo_key_r <= hi_key_r;
      end
      if (!has_hi_r) begin
        hi_idx_r <= lo_idx_r;
        hi_key_r <= lo_key_r;
      end
    end

    if (state_r == S_FETCH_HI) begin
      lo_coef_r <= coef_q;
    end
    if (state_r == S_GRAB_HI) begin
      hi_coef_r <= coef_q;
      den_r     <= den_c;
      rem_r     <= {1'b0, diff_c};
      quo_r     <= '0;
      div_cnt_r <= '0;
      if (den_c == '0) begin
        blend_r <= '0;
      end else if (diff_c >= den_c) begin
        blend_r <= BLEND_ONE;
      end
    end
    if (state_r == S_DIV) begin
      rem_r     <= trial_ge ? (trial - {1'b0, den_r}) : trial;
      quo_r     <= {quo_r[FRAC_W-2:0], trial_ge};
      div_cnt_r <= div_cnt_r + 4'd1;
      if (div_cnt_r == 4'd15) begin
        blend_r <= {1'b0, quo_r[FRAC_W-2:0], trial_ge};
      end
    end

    if (state_r == S_MUL) begin
      mul_cnt_r <= mul_cnt_r + 2'd1;
      if (mul_cnt_r != 2'd3) begin
        prod_r <= diff_w * $signed({1'b0, blend_r});
      end
      case (mul_cnt_r)
        2'd1: res_r.out_a <= lerp_w;
        2'd2: res_r.out_b <= lerp_w;
        2'd3: begin
          res_r.out_c  <= lerp_w;
          res_r.blend  <= blend_r;
          res_r.status <= ST_INTERP;
        end
        default: ;
      endcase
    end else begin
      mul_cnt_r <= '0;
    end

    if (emit_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_INTERP) |->
      (out_data.out_a == '0 && out_data.out_b == '0 &&
       out_data.out_c == '0 && out_data.blend == '0))
    else $error("non-interpolated result carries nonzero fields");

  a_blend_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.blend <= BLEND_ONE))
    else $error("blend above one");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count above table size");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in flight");

endmodule

`default_nettype wire

// ===== design/cti_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module cti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
